FILE: rtl/nrpr_pkg.sv
// Shared constants and types for the Newton-Raphson polynomial root finder.
// No dependencies; imported by newton_raphson_poly_root.
`timescale 1ns / 1ps

package nrpr_pkg;

    // Field widths fixed by the interface.
    localparam int X_W        = 32;
    localparam int V_W        = 48;
    localparam int COEF_W     = 16;
    localparam int TOL_W      = 32;
    localparam int CNT_W      = 7;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Default fraction bits and the most rows in one run.
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_ITER      = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_C4    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C3    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C0    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd6;

    // Row status codes.
    localparam logic [STAT_W-1:0] ST_RUN    = 2'd0;
    localparam logic [STAT_W-1:0] ST_CONV   = 2'd1;
    localparam logic [STAT_W-1:0] ST_LIMIT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_ZSLOPE = 2'd3;

    typedef logic signed [X_W-1:0]    x_t;
    typedef logic signed [V_W-1:0]    val_t;
    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

FILE: rtl/newton_raphson_poly_root.sv
// Newton-Raphson root finder for a quartic with integer coefficients.
// Depends on nrpr_pkg for widths, register indexes and status codes.
//
// Usage: write the five coefficients, the tolerance and the iteration limit
// on the cfg channel (cfg_ready is always high) while the block is idle.
// A request on the input channel carries a Q(32-F).F starting guess x_start.
// Each Newton step yields one result request with the row number, the old
// estimate, f and f' there, the new estimate, the relative change and a
// status; last marks the final row of the run.
// One shared 32x32 multiplier evaluates both polynomials by Horner's scheme
// in seven steps, each through S_MUL_LO, S_MUL_HI, S_MUL_SAT and S_ACC, and
// one restoring divider gives one quotient bit per cycle, first for f/f' and
// then for the relative change. The input channel is stalled for the whole
// run and is released as the last row is loaded into the output register.
// When the receiver stalls, the finished row holds in the output register
// and the next row waits until it is taken. Reset clears the sequencer state
// and out_valid and loads the configuration register reset values.
`timescale 1ns / 1ps

module newton_raphson_poly_root #(
    parameter int FRAC_BITS = nrpr_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Starting guess
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  nrpr_pkg::x_t                          x_start,
    // Result rows
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [nrpr_pkg::CNT_W-1:0]            iteration,
    output nrpr_pkg::x_t                          x_old,
    output nrpr_pkg::val_t                        f_old,
    output nrpr_pkg::val_t                        slope_old,
    output nrpr_pkg::x_t                          x_new,
    output logic [nrpr_pkg::X_W-1:0]              rel_change,
    output logic [nrpr_pkg::STAT_W-1:0]           status,
    output logic                                  last,
    // Configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [nrpr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nrpr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import nrpr_pkg::*;

    localparam int NUM_W    = V_W + FRAC_BITS;
    localparam int DCNT_W   = $clog2(NUM_W);
    localparam int Q_W      = 42;
    localparam int KC_W     = 18;

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_START   = 4'd1;
    localparam logic [3:0] S_MUL_LO  = 4'd2;
    localparam logic [3:0] S_MUL_HI  = 4'd3;
    localparam logic [3:0] S_MUL_SAT = 4'd4;
    localparam logic [3:0] S_ACC     = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_XNEW    = 4'd8;
    localparam logic [3:0] S_REL     = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    // Configuration registers.
    coef_t             c4_reg, c3_reg, c2_reg, c1_reg, c0_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [CNT_W-1:0]  limit_reg;

    // Control state.
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  step_reg;
    logic [2:0]        k_reg;
    logic              poly_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              dmode_reg;
    logic              out_valid_reg;

    // Datapath registers.
    x_t                est_reg;
    logic [X_W-1:0]    xmag_reg;
    logic              xneg_reg;
    val_t              acc_reg;
    logic [63:0]       lb_reg, hb_reg;
    logic signed [V_W:0] prod_reg;
    val_t              f_reg, d_reg;
    logic              conv_reg, zero_reg;
    logic [V_W-1:0]    rem_reg, den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [Q_W-1:0]    q_reg;
    x_t                xn_reg;
    logic [X_W-1:0]    rel_reg;

    // Output registers.
    logic [CNT_W-1:0]  iter_o_reg;
    x_t                xo_o_reg, xn_o_reg;
    val_t              f_o_reg, d_o_reg;
    logic [X_W-1:0]    rel_o_reg;
    logic [STAT_W-1:0] stat_o_reg;
    logic              last_o_reg;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign iteration  = iter_o_reg;
    assign x_old      = xo_o_reg;
    assign f_old      = f_o_reg;
    assign slope_old  = d_o_reg;
    assign x_new      = xn_o_reg;
    assign rel_change = rel_o_reg;
    assign status     = stat_o_reg;
    assign last       = last_o_reg;

    // Coefficient of the current Horner step, f or f'.
    logic signed [KC_W-1:0] kc;
    always_comb
    begin
        kc = '0;
        if (!poly_reg)
        begin
            case (k_reg)
                3'd0:    kc = KC_W'(c4_reg);
                3'd1:    kc = KC_W'(c3_reg);
                3'd2:    kc = KC_W'(c2_reg);
                3'd3:    kc = KC_W'(c1_reg);
                3'd4:    kc = KC_W'(c0_reg);
                default: kc = '0;
            endcase
        end
        else
        begin
            case (k_reg)
                3'd0:    kc = KC_W'(c4_reg) <<< 2;
                3'd1:    kc = (KC_W'(c3_reg) <<< 1) + KC_W'(c3_reg);
                3'd2:    kc = KC_W'(c2_reg) <<< 1;
                3'd3:    kc = KC_W'(c1_reg);
                default: kc = '0;
            endcase
        end
    end

    logic signed [V_W-1:0] kc_scaled;
    assign kc_scaled = V_W'(kc) <<< FRAC_BITS;
    logic [2:0] k_last;
    assign k_last = poly_reg ? 3'd3 : 3'd4;

    // Shared multiplier: low then high half of |acc| times |x|.
    logic [V_W-1:0] acc_mag;
    logic           acc_neg;
    logic [31:0]    mul_a;
    logic [63:0]    mul_p;
    assign acc_neg = acc_reg[V_W-1];
    assign acc_mag = acc_neg ? (~acc_reg + 1'b1) : acc_reg;
    assign mul_a   = (state_reg == S_MUL_LO) ? acc_mag[31:0] : {16'd0, acc_mag[V_W-1:32]};
    assign mul_p   = mul_a * xmag_reg;

    // Rescale and saturate the product.
    logic [64:0]     m_sum, m_cap, m_sat;
    logic            p_neg, hb_big;
    assign p_neg  = acc_neg ^ xneg_reg;
    assign hb_big = |(hb_reg >> (FRAC_BITS + 15));
    assign m_sum  = (65'(hb_reg) << (32 - FRAC_BITS)) + 65'(lb_reg >> FRAC_BITS);
    assign m_cap  = p_neg ? (65'd1 << (V_W - 1)) : ((65'd1 << (V_W - 1)) - 65'd1);
    assign m_sat  = (hb_big || m_sum > m_cap) ? m_cap : m_sum;

    // Add the coefficient and saturate to 48 bits.
    logic signed [V_W+1:0] acc_sum;
    val_t                  acc_new;
    assign acc_sum = (V_W+2)'(prod_reg) + (V_W+2)'(kc_scaled);
    always_comb
    begin
        if (acc_sum[V_W+1] == 1'b0 && acc_sum[V_W:V_W-1] != 2'b00)
            acc_new = {1'b0, {(V_W-1){1'b1}}};
        else if (acc_sum[V_W+1] == 1'b1 && acc_sum[V_W:V_W-1] != 2'b11)
            acc_new = {1'b1, {(V_W-1){1'b0}}};
        else
            acc_new = acc_sum[V_W-1:0];
    end

    // Magnitudes of f and f'.
    logic [V_W-1:0] f_mag, d_mag;
    assign f_mag = f_reg[V_W-1] ? (~f_reg + 1'b1) : f_reg;
    assign d_mag = d_reg[V_W-1] ? (~d_reg + 1'b1) : d_reg;

    // One restoring division step.
    logic [V_W:0]   rem_sh, rem_sub;
    logic           q_bit, cap_hit;
    logic [V_W-1:0] rem_next;
    logic [Q_W-1:0] q_sh;
    assign rem_sh   = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, den_reg});
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign rem_next = q_bit ? rem_sub[V_W-1:0] : rem_sh[V_W-1:0];
    assign q_sh     = {q_reg[Q_W-2:0], q_bit};
    assign cap_hit  = dmode_reg ? (q_sh >= (Q_W'(1) << 32)) : (q_sh >= (Q_W'(1) << 40));

    // New estimate: x_old minus the signed quotient, saturated to 32 bits.
    logic signed [43:0] step_s, xn_wide;
    x_t                 xn_sat;
    assign step_s  = (f_reg[V_W-1] ^ d_reg[V_W-1]) ? -44'(q_reg) : 44'(q_reg);
    assign xn_wide = 44'(est_reg) - step_s;
    always_comb
    begin
        if (xn_wide > 44'sh0007FFFFFFF)
            xn_sat = {1'b0, {(X_W-1){1'b1}}};
        else if (xn_wide < -44'sh00080000000)
            xn_sat = {1'b1, {(X_W-1){1'b0}}};
        else
            xn_sat = xn_wide[X_W-1:0];
    end

    // Relative change operands.
    logic signed [X_W:0] diff;
    logic [X_W:0]        diff_mag;
    logic [X_W-1:0]      xn_mag;
    assign diff     = (X_W+1)'(xn_reg) - (X_W+1)'(est_reg);
    assign diff_mag = diff[X_W] ? (~diff + 1'b1) : diff;
    assign xn_mag   = xn_reg[X_W-1] ? (~xn_reg + 1'b1) : xn_reg;

    // Row status and effective iteration limit.
    logic [CNT_W-1:0]  lim_eff, step_inc;
    logic [STAT_W-1:0] row_stat;
    logic              slot_free;
    assign lim_eff   = (limit_reg == '0) ? CNT_W'(1) :
                       (limit_reg > CNT_W'(MAX_ITER)) ? CNT_W'(MAX_ITER) : limit_reg;
    assign step_inc  = step_reg + 1'b1;
    assign row_stat  = conv_reg ? ST_CONV : zero_reg ? ST_ZSLOPE :
                       (step_inc >= lim_eff) ? ST_LIMIT : ST_RUN;
    assign slot_free = !out_valid_reg || !out_stall;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_START;
            S_START:   state_next = S_MUL_LO;
            S_MUL_LO:  state_next = S_MUL_HI;
            S_MUL_HI:  state_next = S_MUL_SAT;
            S_MUL_SAT: state_next = S_ACC;
            S_ACC:     state_next = (k_reg == k_last && poly_reg) ? S_CHECK : S_MUL_LO;
            S_CHECK:   state_next = (d_reg == '0) ? S_REL : S_DIV;
            S_DIV:
            begin
                if (cap_hit || dcnt_reg == '0)
                    state_next = dmode_reg ? S_EMIT : S_XNEW;
            end
            S_XNEW:    state_next = S_REL;
            S_REL:     state_next = (xn_reg == '0) ? S_EMIT : S_DIV;
            S_EMIT:
            begin
                if (slot_free)
                    state_next = (row_stat != ST_RUN) ? S_IDLE : S_START;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            c4_reg        <= 16'sd1;
            c3_reg        <= -16'sd21;
            c2_reg        <= 16'sd149;
            c1_reg        <= -16'sd399;
            c0_reg        <= 16'sd270;
            tol_reg       <= 32'd3277;
            limit_reg     <= 7'd32;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_C4:    c4_reg    <= cfg_data[COEF_W-1:0];
                    REG_C3:    c3_reg    <= cfg_data[COEF_W-1:0];
                    REG_C2:    c2_reg    <= cfg_data[COEF_W-1:0];
                    REG_C1:    c1_reg    <= cfg_data[COEF_W-1:0];
                    REG_C0:    c0_reg    <= cfg_data[COEF_W-1:0];
                    REG_TOL:   tol_reg   <= cfg_data[TOL_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                est_reg  <= x_start;
                step_reg <= '0;
            end
            S_START:
            begin
                xneg_reg <= est_reg[X_W-1];
                xmag_reg <= est_reg[X_W-1] ? (~est_reg + 1'b1) : est_reg;
                poly_reg <= 1'b0;
                k_reg    <= 3'd1;
                acc_reg  <= V_W'(c4_reg) <<< FRAC_BITS;
            end
            S_MUL_LO:  lb_reg <= mul_p;
            S_MUL_HI:  hb_reg <= mul_p;
            S_MUL_SAT: prod_reg <= p_neg ? -(V_W+1)'(m_sat) : (V_W+1)'(m_sat);
            S_ACC:
            begin
                if (k_reg == k_last)
                begin
                    if (!poly_reg)
                    begin
                        f_reg    <= acc_new;
                        poly_reg <= 1'b1;
                        k_reg    <= 3'd1;
                        acc_reg  <= V_W'(c4_reg) <<< (FRAC_BITS + 2);
                    end
                    else
                    begin
                        d_reg <= acc_new;
                    end
                end
                else
                begin
                    acc_reg <= acc_new;
                    k_reg   <= k_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                conv_reg  <= (f_mag < V_W'(tol_reg));
                zero_reg  <= (d_reg == '0);
                xn_reg    <= est_reg;
                rem_reg   <= '0;
                q_reg     <= '0;
                num_reg   <= NUM_W'(f_mag) << FRAC_BITS;
                den_reg   <= d_mag;
                dcnt_reg  <= DCNT_W'(NUM_W - 1);
                dmode_reg <= 1'b0;
            end
            S_DIV:
            begin
                rem_reg  <= rem_next;
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg - 1'b1;
                if (cap_hit)
                    q_reg <= dmode_reg ? Q_W'(32'hFFFF_FFFF) : (Q_W'(1) << 40);
                else
                    q_reg <= q_sh;
                if (dmode_reg && (cap_hit || dcnt_reg == '0))
                    rel_reg <= cap_hit ? 32'hFFFF_FFFF : q_sh[X_W-1:0];
            end
            S_XNEW:    xn_reg <= xn_sat;
            S_REL:
            begin
                rel_reg   <= '0;
                rem_reg   <= '0;
                q_reg     <= '0;
                num_reg   <= NUM_W'(diff_mag) << FRAC_BITS;
                den_reg   <= V_W'(xn_mag);
                dcnt_reg  <= DCNT_W'(NUM_W - 1);
                dmode_reg <= 1'b1;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    iter_o_reg <= step_inc;
                    xo_o_reg   <= est_reg;
                    f_o_reg    <= f_reg;
                    d_o_reg    <= d_reg;
                    xn_o_reg   <= xn_reg;
                    rel_o_reg  <= rel_reg;
                    stat_o_reg <= row_stat;
                    last_o_reg <= (row_stat != ST_RUN);
                    est_reg    <= xn_reg;
                    step_reg   <= step_inc;
                end
            end
            default: ;
        endcase
    end

    // A new row never overwrites one that the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(iter_o_reg) && $stable(xn_o_reg))
        else $error("held result row changed");

    // The last flag follows the status of the row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != ST_RUN)))
        else $error("last flag disagrees with status");

    // The divider never runs with a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("division by zero");

    // Row numbers are nonzero and stay within MAX_ITER.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (iteration != '0 && iteration <= CNT_W'(MAX_ITER)))
        else $error("row number out of range");

endmodule
